>>> hw/rtl/sphere_surface_sample_defines.svh
// Assertion macros for the sphere surface sampler.
`ifndef SPHERE_SURFACE_SAMPLE_DEFINES_SVH
`define SPHERE_SURFACE_SAMPLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SSS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSS_ASSERT(label, clk, rst, prop, msg)
`define SSS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/sss_pkg.sv
// Shared types and constants for the sphere surface sampler.
package sss_pkg;
   localparam int RadW   = 24;
   localparam int FracW  = 16;
   localparam int OutW   = 25;
   localparam int SqW    = 48;
   localparam int SqSteps = 24;
   localparam int CW     = 36;   // cordic x/y width, units 2^-24
   localparam int PhW    = 33;   // signed phase, units 2^-32 turn
   localparam int AtanEntries = 24;
   localparam logic [30:0] GainQ30 = 31'd652032874;

   // one square-root cell's working set
   typedef struct packed {
      logic [SqW-1:0]  rem;
      logic [RadW-1:0] res;
   } sq_work_type;

   // one cordic cell's working set
   typedef struct packed {
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic signed [PhW-1:0] ph;
   } rot_work_type;

   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
         3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
         6: t = 32'd10680862;   7: t = 32'd5340245;    8: t = 32'd2670163;
         9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
         12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41721;
         15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
         18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
         21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction
endpackage

>>> hw/rtl/sss_sqrt_cell.sv
// One bit-pair step of the restoring square root, registered.
module sss_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  sss_pkg::sq_work_type  work_i,
   output sss_pkg::sq_work_type  work_o
);
   import sss_pkg::*;
   // res holds root bits so far; trial = (res << 2) | 1 against the next bit pair
   localparam int Sh = 2 * (SqSteps - 1 - STEP);
   logic [SqW+1:0] trial;
   logic [SqW+1:0] part;
   sq_work_type work_in, work_ff;

   always_comb begin
      part  = {2'b00, work_i.rem} >> Sh;
      trial = {(SqW-RadW)'(0), work_i.res, 2'b01};
      work_in.rem = work_i.rem;
      work_in.res = {work_i.res[RadW-2:0], 1'b0};
      if (part >= trial) begin
         work_in.rem = work_i.rem - SqW'(trial << Sh);
         work_in.res = {work_i.res[RadW-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) work_ff <= work_in;
   end
   assign work_o = work_ff;
endmodule

>>> hw/rtl/sss_cordic_cell.sv
// One CORDIC rotation step, registered.
module sss_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  sss_pkg::rot_work_type  work_i,
   output sss_pkg::rot_work_type  work_o
);
   import sss_pkg::*;
   logic signed [CW-1:0] dx, dy;
   logic signed [PhW-1:0] ang;
   rot_work_type work_in, work_ff;

   always_comb begin
      dx  = work_i.y >>> STEP;
      dy  = work_i.x >>> STEP;
      ang = PhW'($signed({1'b0, atan_turns(STEP)}));
      if (!work_i.ph[PhW-1]) begin
         work_in.x  = work_i.x - dx;
         work_in.y  = work_i.y + dy;
         work_in.ph = work_i.ph - ang;
      end else begin
         work_in.x  = work_i.x + dx;
         work_in.y  = work_i.y - dy;
         work_in.ph = work_i.ph + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) work_ff <= work_in;
   end
   assign work_o = work_ff;
endmodule

>>> hw/rtl/sphere_surface_sample.sv
// Top level of the sphere surface sampler: height, square-root row, CORDIC row.
//
// Use: req_tdata carries {angle_fraction, height_fraction}, two Q0.16 fractions.
// Each accepted request yields one point on rsp_tdata as {point_z, point_y,
// point_x}, each signed Q8.16, on a sphere of radius csr_tdata (Q8.16).
// Pipeline: height (3 stages), 24 square-root cells, gain multiply, quadrant fold,
// CORDIC_STEPS rotation cells (steps capped at 24), rounding/clamp stage.
// Throughput one request per cycle while the output is not stalled; the whole pipe
// advances together.
// When the receiver stalls with rsp_tvalid high the pipe freezes and req_tready
// drops only if the output register is full and unread.
// Reset empties the pipe (valid bits cleared) and sets the radius to 1.0.
// The radius may be written only while no request is in flight; it is read at
// the first stage and carried along with each request.
module sphere_surface_sample #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] height_fraction, [31:16] angle_fraction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [24:0] point_x, [49:25] point_y, [74:50] point_z
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [23:0] csr_tdata    // [23:0] radius
);
   import sss_pkg::*;
`include "sphere_surface_sample_defines.svh"

   localparam int NStep = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
   localparam int Depth = 6 + SqSteps + NStep;

   logic adv;
   logic [Depth-1:0] vld_ff;
   logic [RadW-1:0] radius_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[Depth-1];
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= 24'd65536;
      end else begin
         if (csr_tvalid) radius_ff <= csr_tdata;
         if (adv) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end

   // stage 0: product r*t
   logic signed [42:0] p_ff;
   logic [RadW-1:0] r0_ff;
   logic [FracW-1:0] v0_ff;
   // stage 1: z and squares
   logic signed [OutW-1:0] z1_ff;
   logic [RadW-1:0] r1_ff;
   logic [FracW-1:0] v1_ff;
   logic [SqW-1:0] d2_ff;
   logic [FracW-1:0] v2_ff;
   logic signed [OutW-1:0] z2_ff;
   logic [41:0] pa;
   logic [OutW-1:0] zmag;
   logic [SqW-1:0] rr, zz;

   always_comb begin
      pa   = p_ff[42] ? 42'(-p_ff) : 42'(p_ff);
      zmag = OutW'((pa + 42'd32768) >> 16);
      rr   = SqW'(r1_ff) * SqW'(r1_ff);
      zz   = SqW'(z1_ff[OutW-1] ? -z1_ff : z1_ff);
      zz   = zz * zz;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff  <= $signed({1'b0, radius_ff}) *
                  $signed(18'({1'b0, req_tdata[15:0], 1'b0}) - 18'sd65536);
         r0_ff <= radius_ff;
         v0_ff <= req_tdata[31:16];
         z1_ff <= p_ff[42] ? -$signed(zmag) : $signed(zmag);
         r1_ff <= r0_ff;
         v1_ff <= v0_ff;
         d2_ff <= rr - zz;
         v2_ff <= v1_ff;
         z2_ff <= z1_ff;
      end
   end

   // square-root row; phase and z ride along in delay taps
   sq_work_type sq_w [SqSteps+1];
   logic [FracW-1:0] v_tap_ff [SqSteps+1];
   logic signed [OutW-1:0] z_tap_ff [SqSteps+1];
   assign sq_w[0]     = '{rem: d2_ff, res: '0};
   assign v_tap_ff[0] = v2_ff;
   assign z_tap_ff[0] = z2_ff;
   for (genvar i = 0; i < SqSteps; i++) begin : g_sq
      sss_sqrt_cell #(.STEP(i)) u_cell (
         .clock(clock), .enable(adv), .work_i(sq_w[i]), .work_o(sq_w[i+1]));
      always_ff @(posedge clock) begin
         if (adv) begin
            v_tap_ff[i+1] <= v_tap_ff[i];
            z_tap_ff[i+1] <= z_tap_ff[i];
         end
      end
   end

   // gain multiply
   logic [RadW-1:0] a3_ff;
   logic [54:0] g3_ff;
   logic [FracW-1:0] v3_ff;
   logic signed [OutW-1:0] z3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff <= sq_w[SqSteps].res;
         g3_ff <= 55'(sq_w[SqSteps].res) * 55'(GainQ30);
         v3_ff <= v_tap_ff[SqSteps];
         z3_ff <= z_tap_ff[SqSteps];
      end
   end

   // quadrant fold into CORDIC entry
   rot_work_type rw [NStep+1];
   rot_work_type fold;
   logic signed [CW-1:0] x0;
   logic [RadW-1:0] a_tap_ff [NStep+1];
   logic signed [OutW-1:0] zc_tap_ff [NStep+1];
   always_comb begin
      x0      = CW'($signed({1'b0, 34'((g3_ff + 55'd2097152) >> 22)}));
      fold.x  = x0;
      fold.y  = '0;
      fold.ph = $signed({1'b0, v3_ff, 16'd0});
      if (v3_ff[15] != v3_ff[14]) begin
         fold.x  = -x0;
         fold.ph = fold.ph - $signed({2'b01, 31'd0});
      end else if (v3_ff[15]) begin
         fold.ph = fold.ph - $signed({1'b1, 32'd0});
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rw[0]        <= fold;
         a_tap_ff[0]  <= a3_ff;
         zc_tap_ff[0] <= z3_ff;
      end
   end
   for (genvar j = 0; j < NStep; j++) begin : g_rot
      sss_cordic_cell #(.STEP(j)) u_cell (
         .clock(clock), .enable(adv), .work_i(rw[j]), .work_o(rw[j+1]));
      always_ff @(posedge clock) begin
         if (adv) begin
            a_tap_ff[j+1]  <= a_tap_ff[j];
            zc_tap_ff[j+1] <= zc_tap_ff[j];
         end
      end
   end

   // round and clamp to [-a, a]
   logic signed [CW-9:0] px, py;
   logic signed [CW-9:0] amax;
   logic signed [OutW-1:0] ox, oy;
   always_comb begin
      px   = (CW-8)'((rw[NStep].x + CW'(128)) >>> 8);
      py   = (CW-8)'((rw[NStep].y + CW'(128)) >>> 8);
      amax = $signed({4'b0, a_tap_ff[NStep]});
      ox = OutW'(px);
      oy = OutW'(py);
      if (px > amax) ox = OutW'(amax);
      if (px < -amax) ox = OutW'(-amax);
      if (py > amax) oy = OutW'(amax);
      if (py < -amax) oy = OutW'(-amax);
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_tdata <= {5'd0, zc_tap_ff[NStep], oy, ox};
   end

   `SSS_ASSERT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "lost")
   `SSS_ASSERT(a_ready, clock, reset, !rsp_tvalid |-> req_tready, "not ready")
   `SSS_ASSERT(a_stall_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "data")
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sphere surface sampler.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sss_pkg::*;

   localparam int Steps   = 16;
   localparam int Latency = 30 + Steps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [23:0] csr_tdata = '0;

   // one expected point, x in the lowest bits as on rsp_tdata
   typedef struct packed {
      logic [OutW-1:0] pz;
      logic [OutW-1:0] py;
      logic [OutW-1:0] px;
   } point_type;

   // directed request, with the point typed in where obvious
   typedef struct {
      logic [23:0] radius;
      logic [15:0] u;
      logic [15:0] v;
      bit          known;
      point_type   pt;
   } row_type;

   point_type   points_due[$];
   logic [23:0] radius_now;
   int          mismatches = 0;
   int          stall_left = 0;

   sphere_surface_sample #(.CORDIC_STEPS(Steps)) dut (.*);

   always #6 clock = ~clock;

   // floor division by a power of two (arithmetic shift), rounding helper
   function automatic longint floor_shift(longint val, int s);
      return val >>> s;
   endfunction

   // point on the sphere for a radius and two fractions
   function automatic point_type sphere_point(logic [23:0] rad, logic [15:0] u, logic [15:0] v);
      longint r, t, p, z, rem, root, bit_w, x, y, ph, dx, dy, px, py;
      point_type o;
      r = rad;
      t = 2 * longint'(u) - 65536;
      p = r * t;
      z = (p >= 0) ? ((p + 32768) >>> 16) : -(((-p) + 32768) >>> 16);
      // bitwise square root of r^2 - z^2
      rem = r * r - z * z;
      root = 0;
      bit_w = 64'sd1 << 46;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem -= root + bit_w;
            root = (root >>> 1) + bit_w;
         end else begin
            root = root >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      ph = longint'(v) << 16;
      x = (root * 652032874 + (64'sd1 << 21)) >>> 22;
      y = 0;
      // quadrant fold: residual lies within a quarter turn either side
      if (ph >= (64'sd1 << 30) && ph < (64'sd3 << 30)) begin
         x = -x;
         ph -= 64'sd1 << 31;
      end else if (ph >= (64'sd3 << 30)) begin
         ph -= 64'sd1 << 32;
      end
      for (int i = 0; i < Steps && i < AtanEntries; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (ph >= 0) begin
            x -= dx; y += dy; ph -= longint'(atan_turns(i));
         end else begin
            x += dx; y -= dy; ph += longint'(atan_turns(i));
         end
      end
      px = floor_shift(x + 128, 8);
      py = floor_shift(y + 128, 8);
      // clamp away the residual gain error
      if (px > root) px = root;
      if (px < -root) px = -root;
      if (py > root) py = root;
      if (py < -root) py = -root;
      o.px = px[OutW-1:0];
      o.py = py[OutW-1:0];
      o.pz = z[OutW-1:0];
      return o;
   endfunction

   function automatic point_type pt_of(longint x, longint y, longint z);
      point_type o;
      o.px = x[OutW-1:0]; o.py = y[OutW-1:0]; o.pz = z[OutW-1:0];
      return o;
   endfunction

   // short gap: mostly none, sometimes a few, rarely long
   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_radius(logic [23:0] val);
      // drain the pipe before touching the radius
      while (points_due.size() != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= val;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      radius_now = val;
   endtask

   task automatic send_request(logic [15:0] u, logic [15:0] v, bit known, point_type pt);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, u};
      do @(posedge clock); while (!req_tready);
      points_due.insert(points_due.size(), known ? pt : sphere_point(radius_now, u, v));
   endtask

   // response side: random stalls, compare against the oldest expected point
   always @(posedge clock) begin
      point_type want, got;
      int g;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[74:0];
            if (points_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected point %h", got);
            end else begin
               want = points_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: x %h/%h y %h/%h z %h/%h (exp/act)",
                              want.px, got.px, want.py, got.py, want.pz, got.pz);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = g - 1;
            end
         end
      end
   end

   initial begin
      row_type rows[18];
      logic [23:0] radii[6];
      reset = 1'b1;
      radius_now = 24'd65536;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         // after reset r = 1.0: poles, points on the equator axes and mid-latitudes
         '{24'd65536, 16'h0000, 16'h0000, 1'b1, pt_of(0, 0, -65536)},
         '{24'd65536, 16'h8000, 16'h0000, 1'b0, '0},
         '{24'd65536, 16'h8000, 16'h4000, 1'b0, '0},
         '{24'd65536, 16'h8000, 16'h8000, 1'b0, '0},
         '{24'd65536, 16'h8000, 16'hC000, 1'b0, '0},
         '{24'd65536, 16'hFFFF, 16'hFFFF, 1'b0, '0},
         '{24'd65536, 16'h4000, 16'h3FFF, 1'b0, '0},
         '{24'd65536, 16'hC000, 16'hBFFF, 1'b0, '0},
         // zero radius: everything collapses to the origin
         '{24'd0, 16'hFFFF, 16'h1234, 1'b1, pt_of(0, 0, 0)},
         '{24'd0, 16'h0000, 16'hFFFF, 1'b1, pt_of(0, 0, 0)},
         // largest radius, south pole and extremes of both fractions; then radius 1
         '{24'hFFFFFF, 16'h0000, 16'h0000, 1'b1, pt_of(0, 0, -16777215)},
         '{24'hFFFFFF, 16'h8000, 16'h0000, 1'b0, '0},
         '{24'hFFFFFF, 16'h8000, 16'h2000, 1'b0, '0},
         '{24'hFFFFFF, 16'h8000, 16'h6000, 1'b0, '0},
         '{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
         '{24'hFFFFFF, 16'h5555, 16'hAAAA, 1'b0, '0},
         '{24'd1, 16'h8000, 16'h4000, 1'b0, '0},
         '{24'd1, 16'hC000, 16'h0001, 1'b0, '0}
      };

      foreach (rows[i]) begin
         if (rows[i].radius != radius_now) begin
            req_tvalid <= 1'b0;
            write_radius(rows[i].radius);
         end
         send_request(rows[i].u, rows[i].v, rows[i].known, rows[i].pt);
      end

      // random phases over several radii, small, middling, extreme
      radii = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd1, 24'h000000, 24'h000000};
      radii[4] = 24'($urandom_range(1, 24'hFFFFFE));
      radii[5] = 24'($urandom_range(1, 24'h0FFFFF));
      for (int ph = 0; ph < 6; ph++) begin
         req_tvalid <= 1'b0;
         write_radius(radii[ph]);
         for (int n = 0; n < 64; n++)
            send_request(16'($urandom_range(0, 16'hFFFF)),
                         16'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (points_due.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (mismatches == 0 && points_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sss_pkg.sv
hw/rtl/sss_sqrt_cell.sv
hw/rtl/sss_cordic_cell.sv
hw/rtl/sphere_surface_sample.sv
tb/sv/testbench.sv
